[src/ssfe_pkg.sv]
package ssfe_pkg;

    // Display geometry and frame size
    localparam int NumDigits = 4;
    localparam int FrameMax  = NumDigits + 1;

    // Request codes
    localparam logic [2:0] ReqRaw      = 3'd0;
    localparam logic [2:0] ReqDecDigit = 3'd1;
    localparam logic [2:0] ReqHexDigit = 3'd2;
    localparam logic [2:0] ReqDecNum   = 3'd3;
    localparam logic [2:0] ReqHexNum   = 3'd4;
    localparam logic [2:0] ReqClear    = 3'd5;
    localparam logic [2:0] ReqBright   = 3'd6;

    // Frame command bytes
    localparam logic [7:0] CmdDisplay = 8'h08;
    localparam logic [7:0] CmdBright  = 8'h18;
    localparam logic [7:0] BrightBase = 8'h10;

    localparam logic [15:0] DecMax    = 16'd9999;
    localparam logic [3:0]  BrightMax = 4'd8;

    // Reciprocals for dividing a value up to 9999 by 1000, 100 and 10
    localparam logic [17:0] Recip1000 = 18'd16778;   // 2^24 / 1000, rounded up
    localparam logic [17:0] Recip100  = 18'd167773;  // 2^24 / 100, rounded up
    localparam logic [17:0] Recip10   = 18'd104858;  // 2^20 / 10, rounded up

    typedef logic [NumDigits-1:0][7:0] t_digits;

    typedef struct packed {
        logic [FrameMax-1:0][7:0] bytes;  // byte 0 goes out first
        logic [2:0]               len;    // 0 means no frame
    } t_frame;

    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'h0: s = 8'h3F;
            4'h1: s = 8'h06;
            4'h2: s = 8'h5B;
            4'h3: s = 8'h4F;
            4'h4: s = 8'h66;
            4'h5: s = 8'h6D;
            4'h6: s = 8'h7D;
            4'h7: s = 8'h07;
            4'h8: s = 8'h7F;
            4'h9: s = 8'h6F;
            4'hA: s = 8'h77;
            4'hB: s = 8'h7C;
            4'hC: s = 8'h39;
            4'hD: s = 8'h5E;
            4'hE: s = 8'h79;
            4'hF: s = 8'h71;
            default: s = 8'h3F;
        endcase
        return s;
    endfunction

endpackage

[src/ssfe_frame_build.sv]
module ssfe_frame_build (
    input  logic [2:0]        i_req,
    input  logic [15:0]       i_value,
    input  logic [2:0]        i_pos,
    input  logic              i_lz,
    input  logic [13:0]       i_num,
    input  logic [3:0]        i_q1000,
    input  logic [6:0]        i_q100,
    input  logic [9:0]        i_q10,
    input  ssfe_pkg::t_digits i_digits,
    output ssfe_pkg::t_digits o_digits,
    output ssfe_pkg::t_frame  o_frame
);

    logic [6:0]       q1000_x10;
    logic [9:0]       q100_x10;
    logic [13:0]      q10_x10;
    logic [6:0]       rem2;
    logic [9:0]       rem1;
    logic [13:0]      rem0;
    logic [3:0][3:0]  dec_nib;
    logic [3:0][3:0]  hex_nib;
    logic [2:0]       dec_lead;
    logic [2:0]       hex_lead;
    ssfe_pkg::t_digits num_segs;
    logic [7:0]       pat;
    logic [3:0]       lvl;
    logic [3:0]       lvl_m1;
    logic             disp;

    // Decimal digits from the quotients: digit = q(n/w) - 10*q(n/10w)
    assign q1000_x10 = {i_q1000, 3'b000} + {2'b00, i_q1000, 1'b0};
    assign q100_x10  = {i_q100, 3'b000} + {2'b00, i_q100, 1'b0};
    assign q10_x10   = {1'b0, i_q10, 3'b000} + {3'b000, i_q10, 1'b0};
    assign rem2      = i_q100 - q1000_x10;
    assign rem1      = i_q10 - q100_x10;
    assign rem0      = i_num - q10_x10;

    assign dec_nib[0] = i_q1000;
    assign dec_nib[1] = rem2[3:0];
    assign dec_nib[2] = rem1[3:0];
    assign dec_nib[3] = rem0[3:0];

    assign hex_nib[0] = i_value[15:12];
    assign hex_nib[1] = i_value[11:8];
    assign hex_nib[2] = i_value[7:4];
    assign hex_nib[3] = i_value[3:0];

    // Number smaller than the place weight of digits 0..2
    assign dec_lead[0] = (i_num < 14'd1000);
    assign dec_lead[1] = (i_num < 14'd100);
    assign dec_lead[2] = (i_num < 14'd10);
    assign hex_lead[0] = (i_value[15:12] == 4'h0);
    assign hex_lead[1] = (i_value[15:8] == 8'h00);
    assign hex_lead[2] = (i_value[15:4] == 12'h000);

    always_comb begin
        for (int k = 0; k < ssfe_pkg::NumDigits; k++) begin
            if (i_req == ssfe_pkg::ReqHexNum) begin
                num_segs[k] = ssfe_pkg::seg_of(hex_nib[k]);
            end else begin
                num_segs[k] = ssfe_pkg::seg_of(dec_nib[k]);
            end
        end
        // Blank leading zeros; the last digit always shows
        for (int k = 0; k < ssfe_pkg::NumDigits - 1; k++) begin
            if (!i_lz && ((i_req == ssfe_pkg::ReqHexNum) ? hex_lead[k] : dec_lead[k])) begin
                num_segs[k] = 8'h00;
            end
        end
    end

    always_comb begin
        case (i_req)
            ssfe_pkg::ReqRaw:      pat = i_value[7:0];
            ssfe_pkg::ReqDecDigit: pat = ssfe_pkg::seg_of((i_value > 16'd9) ? 4'h0 : i_value[3:0]);
            ssfe_pkg::ReqHexDigit: pat = ssfe_pkg::seg_of((i_value > 16'd15) ? 4'h0 : i_value[3:0]);
            default:               pat = 8'h00;
        endcase
    end

    assign lvl    = (i_value > {12'h000, ssfe_pkg::BrightMax}) ? ssfe_pkg::BrightMax
                                                               : i_value[3:0];
    assign lvl_m1 = lvl - 4'd1;

    always_comb begin
        o_digits = i_digits;
        o_frame  = '0;
        disp     = 1'b0;
        case (i_req)
            ssfe_pkg::ReqRaw, ssfe_pkg::ReqDecDigit, ssfe_pkg::ReqHexDigit: begin
                if (!i_pos[2]) begin
                    o_digits[i_pos[1:0]] = pat;
                    disp = 1'b1;
                end
            end
            ssfe_pkg::ReqDecNum, ssfe_pkg::ReqHexNum: begin
                o_digits = num_segs;
                disp     = 1'b1;
            end
            ssfe_pkg::ReqClear: begin
                o_digits = '0;
                disp     = 1'b1;
            end
            ssfe_pkg::ReqBright: begin
                o_frame.bytes[0] = ssfe_pkg::CmdBright;
                o_frame.bytes[1] = ssfe_pkg::BrightBase
                                 | {4'h0, lvl_m1[0], lvl_m1[1], lvl_m1[2], lvl_m1[3]};
                o_frame.len      = 3'd2;
            end
            default: begin
                o_frame = '0;
            end
        endcase
        if (disp) begin
            o_frame.bytes[0] = ssfe_pkg::CmdDisplay;
            for (int k = 0; k < ssfe_pkg::NumDigits; k++) begin
                o_frame.bytes[k+1] = o_digits[k];
            end
            o_frame.len = 3'(ssfe_pkg::FrameMax);
        end
    end

endmodule

[src/ssfe_tx_shift.sv]
module ssfe_tx_shift (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ssfe_pkg::t_frame i_frame,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [7:0]       o_tx_byte,
    output logic             o_frame_last,
    output logic             o_can_load
);

    logic [ssfe_pkg::FrameMax-1:0][7:0] r_bytes;
    logic [2:0]                         r_rem;
    logic                               take;

    assign o_valid      = (r_rem != 3'd0);
    assign o_tx_byte    = r_bytes[0];
    assign o_frame_last = (r_rem == 3'd1);
    assign take         = o_valid && i_ready;
    // Room for a new frame once the last word of this one leaves
    assign o_can_load   = !o_valid || (o_frame_last && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 3'd0;
        end else if (i_load) begin
            r_rem <= i_frame.len;
        end else if (take) begin
            r_rem <= r_rem - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_frame.bytes;
        end else if (take) begin
            r_bytes <= {8'h00, r_bytes[ssfe_pkg::FrameMax-1:1]};
        end
    end

endmodule

[src/seven_segment_frame_encoder_top.sv]
// Channel  | Direction | Handshake          | Word
// request  | in        | i_valid / o_ready  | i_req_type, i_value, i_digit_pos, i_leading_zeros
// frame    | out       | o_valid / i_ready  | o_tx_byte, o_frame_last
//
// A request passes an input register, a divide-by-constant multiply stage and the
// frame builder, which loads the frame into the output shift register. When idle,
// its first word is valid once that register holds the frame.
// Display frames are 5 words long, brightness frames 2; the output shift register
// sets the sustained rate and takes the next frame as the last word of this one leaves.
// Requests that emit nothing retire in the builder stage without producing output words.
// Reset (synchronous, active low) clears the pipeline and blanks all digits.
// Stalls on i_ready hold the current word and back up through both stages.
module seven_segment_frame_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_value,
    input  logic [2:0]  i_digit_pos,
    input  logic        i_leading_zeros,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_frame_last
);

    // Stage 1: captured request
    logic        r_s1_v;
    logic [2:0]  r_s1_req;
    logic [15:0] r_s1_value;
    logic [2:0]  r_s1_pos;
    logic        r_s1_lz;

    // Stage 2: request plus quotients of the clamped decimal number
    logic        r_s2_v;
    logic [2:0]  r_s2_req;
    logic [15:0] r_s2_value;
    logic [2:0]  r_s2_pos;
    logic        r_s2_lz;
    logic [13:0] r_s2_num;
    logic [3:0]  r_s2_q1000;
    logic [6:0]  r_s2_q100;
    logic [9:0]  r_s2_q10;

    // Segment store, digit 0 is the leftmost (thousands) place
    ssfe_pkg::t_digits r_digits;
    ssfe_pkg::t_digits n_digits;
    ssfe_pkg::t_frame  frame;

    logic [13:0] num;
    logic [31:0] p1000;
    logic [31:0] p100;
    logic [31:0] p10;
    logic        can_load;
    logic        s2_emits;
    logic        s2_take;
    logic        s2_free;
    logic        s1_free;
    logic        load;

    // Handshake across the stages: advance when the next stage is free or draining
    assign s2_emits = (frame.len != 3'd0);
    assign s2_take  = r_s2_v && (!s2_emits || can_load);
    assign s2_free  = !r_s2_v || s2_take;
    assign s1_free  = !r_s1_v || s2_free;
    assign o_ready  = s1_free;
    assign load     = s2_take && s2_emits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_free) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_valid) begin
            r_s1_req   <= i_req_type;
            r_s1_value <= i_value;
            r_s1_pos   <= i_digit_pos;
            r_s1_lz    <= i_leading_zeros;
        end
    end

    // Clamp the decimal number, then divide by 1000, 100 and 10 through reciprocals
    assign num   = (r_s1_value > ssfe_pkg::DecMax) ? ssfe_pkg::DecMax[13:0]
                                                   : r_s1_value[13:0];
    assign p1000 = {18'h0, num} * {14'h0, ssfe_pkg::Recip1000};
    assign p100  = {18'h0, num} * {14'h0, ssfe_pkg::Recip100};
    assign p10   = {18'h0, num} * {14'h0, ssfe_pkg::Recip10};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_free) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1_v) begin
            r_s2_req   <= r_s1_req;
            r_s2_value <= r_s1_value;
            r_s2_pos   <= r_s1_pos;
            r_s2_lz    <= r_s1_lz;
            r_s2_num   <= num;
            r_s2_q1000 <= p1000[27:24];
            r_s2_q100  <= p100[30:24];
            r_s2_q10   <= p10[29:20];
        end
    end

    ssfe_frame_build u_build (
        .i_req    (r_s2_req),
        .i_value  (r_s2_value),
        .i_pos    (r_s2_pos),
        .i_lz     (r_s2_lz),
        .i_num    (r_s2_num),
        .i_q1000  (r_s2_q1000),
        .i_q100   (r_s2_q100),
        .i_q10    (r_s2_q10),
        .i_digits (r_digits),
        .o_digits (n_digits),
        .o_frame  (frame)
    );

    // Commit the store as the request leaves the builder; dropped requests change nothing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits <= '0;
        end else if (s2_take) begin
            r_digits <= n_digits;
        end
    end

    ssfe_tx_shift u_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_frame      (frame),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_tx_byte    (o_tx_byte),
        .o_frame_last (o_frame_last),
        .o_can_load   (can_load)
    );

endmodule

[src/ssfe_checker.sv]
module ssfe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_tx_byte,
    input logic        o_frame_last
);

    logic [2:0] r_pos;

    // Word position inside the current output frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'd0;
        end else if (o_valid && i_ready) begin
            r_pos <= o_frame_last ? 3'd0 : r_pos + 3'd1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tx_byte) && $stable(o_frame_last))
        else $error("output word changed while stalled");

    a_frame_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_pos == 3'd0) |->
            o_tx_byte == ssfe_pkg::CmdDisplay || o_tx_byte == ssfe_pkg::CmdBright)
        else $error("frame does not open with a command byte");

    a_last_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_last |-> r_pos == 3'd1 || r_pos == 3'd4)
        else $error("frame ends at a wrong position");

    a_display_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_pos == 3'd4) |-> o_frame_last)
        else $error("display frame longer than five words");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind seven_segment_frame_encoder_top ssfe_checker u_ssfe_checker (.*);
